// File: rtl/core/saf_pkg.sv
// ----------------------------------------------------------------------------
// saf_pkg
// Shared types and constants of the sensor angle filter.
// ----------------------------------------------------------------------------
package saf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int ANGLE_W  = 15;
    localparam int AVG_W    = 12;
    localparam int MV_W     = 13;
    localparam int CFG_W    = 15;

    localparam logic [SAMPLE_W-1:0] WINDOW_INIT = 12'd2048;
    localparam logic [10:0]         ADC_CLAMP   = 11'd2047;

    localparam int MAC_W   = 28;
    localparam int MAC_P_W = 2 * MAC_W;
    localparam int MAC_C_W = 40;

    // Exact division by 2047 for numerators below 2**26.
    localparam int          RECIP_SHIFT = 37;
    localparam logic [26:0] RECIP_2047  = 27'd67141649;
    localparam int          ROUND_2047  = 1023;

    localparam int MV_SCALE  = 3300;
    localparam int ALPHA     = 77;
    localparam int HALF_TURN = 11520;
    localparam int FULL_TURN = 23040;

    localparam logic [14:0] RANGE_RESET = 15'd23040;

    typedef enum logic [1:0] {
        REG_RANGE,
        REG_MIDPOINT,
        REG_OFFSET,
        REG_INVERT
    } reg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0]        angle_range;
        logic [CFG_W-1:0]        angle_midpoint;
        logic signed [CFG_W-1:0] angle_offset;
        logic                    invert_polarity;
    } cfg_t;

    typedef struct packed {
        logic                      en;
        logic signed [MAC_W-1:0]   a;
        logic signed [MAC_W-1:0]   b;
        logic signed [MAC_C_W-1:0] c;
    } mac_req_t;

    typedef struct packed {
        logic wr_en;
        logic sum_update;
    } win_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_AVG,
        ST_MV_NUM,
        ST_MV_DIV,
        ST_RAW_NUM,
        ST_RAW_DIV,
        ST_WRAP,
        ST_CLAMP,
        ST_DIFF,
        ST_SMOOTH,
        ST_UPDATE,
        ST_OUT
    } state_t;

endpackage

// File: rtl/core/saf_window.sv
// ----------------------------------------------------------------------------
// saf_window
// Circular sample window with its running sum.
// ----------------------------------------------------------------------------
module saf_window #(
    parameter int DEPTH = 10,
    localparam int SUM_W = saf_pkg::SAMPLE_W + $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  saf_pkg::win_ctl_t             ctl,
    input  logic [saf_pkg::SAMPLE_W-1:0]  sample_in,
    output logic [saf_pkg::SAMPLE_W-1:0]  sample,
    output logic [SUM_W-1:0]              sum
);

    localparam int              POS_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_INIT = SUM_W'(2048 * DEPTH);

    logic [saf_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [saf_pkg::SAMPLE_W-1:0] rd_reg;
    logic [saf_pkg::SAMPLE_W-1:0] sample_reg;
    logic [saf_pkg::SAMPLE_W-1:0] old_sample;
    logic                         old_valid_reg;
    logic [DEPTH-1:0]             valid_reg;
    logic [POS_W-1:0]             pos_reg;
    logic [POS_W-1:0]             pos_next;
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;

    // Entries never written since reset read as the initial window value.
    assign old_sample = old_valid_reg ? rd_reg : saf_pkg::WINDOW_INIT;
    assign pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[pos_reg] <= sample_in;
            rd_reg       <= mem[pos_reg];
            sample_reg   <= sample_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= SUM_INIT;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                old_valid_reg      <= valid_reg[pos_reg];
                valid_reg[pos_reg] <= 1'b1;
                pos_reg            <= pos_next;
            end
            if (ctl.sum_update)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    assign sample = sample_reg;
    assign sum    = sum_reg;

endmodule

// File: rtl/core/saf_mac.sv
// ----------------------------------------------------------------------------
// saf_mac
// Shared signed multiply-add unit with a registered product.
// ----------------------------------------------------------------------------
module saf_mac (
    input  logic                                 clk,
    input  saf_pkg::mac_req_t                    req,
    output logic signed [saf_pkg::MAC_P_W-1:0]   prod
);

    logic signed [saf_pkg::MAC_P_W-1:0] mul;
    logic signed [saf_pkg::MAC_P_W-1:0] prod_next;
    logic signed [saf_pkg::MAC_P_W-1:0] prod_reg;

    assign mul       = req.a * req.b;
    assign prod_next = mul + saf_pkg::MAC_P_W'(req.c);

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/saf_ctrl.sv
// ----------------------------------------------------------------------------
// saf_ctrl
// Sequencer that steps one word through averaging, scaling and smoothing.
// ----------------------------------------------------------------------------
module saf_ctrl #(
    parameter int DEPTH = 10,
    localparam int SUM_W = saf_pkg::SAMPLE_W + $clog2(DEPTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  saf_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    output saf_pkg::win_ctl_t                   win_ctl,
    input  logic [saf_pkg::SAMPLE_W-1:0]        sample,
    input  logic [SUM_W-1:0]                    sum,
    output saf_pkg::mac_req_t                   mac_req,
    input  logic signed [saf_pkg::MAC_P_W-1:0]  prod,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [saf_pkg::ANGLE_W-1:0]         smoothed_angle,
    output logic [saf_pkg::AVG_W-1:0]           averaged_adc,
    output logic [saf_pkg::MV_W-1:0]            sample_millivolts
);

    localparam int MW    = saf_pkg::MAC_W;
    localparam int CW    = saf_pkg::MAC_C_W;
    localparam int K_D   = SUM_W + $clog2(DEPTH);
    localparam longint RECIP_D = ((longint'(1) << K_D) + longint'(DEPTH) - 1) / longint'(DEPTH);
    localparam int RS    = saf_pkg::RECIP_SHIFT;
    localparam int RW    = 18;
    localparam int SW    = 19;
    localparam int STW   = 25;
    localparam int DW    = 26;

    saf_pkg::state_t state_reg;
    saf_pkg::state_t state_next;

    logic [saf_pkg::AVG_W-1:0]    avg_reg;
    logic [saf_pkg::MV_W-1:0]     mv_reg;
    logic signed [RW-1:0]         rel_reg;
    logic signed [RW-1:0]         rel_next;
    logic signed [RW-1:0]         diff_raw;
    logic [15:0]                  scaled_angle;
    logic signed [SW-1:0]         shifted;
    logic signed [SW-1:0]         half_s;
    logic signed [SW-1:0]         clamped;
    logic signed [saf_pkg::ANGLE_W-1:0] angle_reg;
    logic signed [DW-1:0]         diff_reg;
    logic signed [DW-1:0]         diff_next;
    logic signed [STW-1:0]        smooth_reg;
    logic signed [DW-1:0]         rounded;
    logic signed [17:0]           result;
    logic signed [17:0]           result_pol;
    logic [10:0]                  avg_clamped;
    logic                         out_load;

    logic                         out_valid_reg;
    logic [saf_pkg::ANGLE_W-1:0]  out_angle_reg;
    logic [saf_pkg::AVG_W-1:0]    out_avg_reg;
    logic [saf_pkg::MV_W-1:0]     out_mv_reg;

    assign avg_clamped = (avg_reg > saf_pkg::AVG_W'(saf_pkg::ADC_CLAMP))
                         ? saf_pkg::ADC_CLAMP : avg_reg[10:0];

    // The wrap applies a single turn of correction.
    assign scaled_angle = prod[RS +: 16];
    assign diff_raw  = $signed({2'b00, scaled_angle}) - $signed({3'b000, cfg.angle_midpoint});
    always_comb
    begin
        rel_next = diff_raw;
        if (diff_raw > RW'(saf_pkg::HALF_TURN))
        begin
            rel_next = diff_raw - RW'(saf_pkg::FULL_TURN);
        end
        else if (diff_raw < -RW'(saf_pkg::HALF_TURN))
        begin
            rel_next = diff_raw + RW'(saf_pkg::FULL_TURN);
        end
    end

    assign shifted = SW'(rel_reg) + SW'(cfg.angle_offset);
    assign half_s  = $signed({5'b00000, cfg.angle_range[14:1]});
    always_comb
    begin
        clamped = shifted;
        if (shifted > half_s)
        begin
            clamped = half_s;
        end
        else if (shifted < -half_s)
        begin
            clamped = -half_s;
        end
    end

    assign diff_next  = DW'($signed({angle_reg, 8'h00})) - DW'(smooth_reg);
    assign rounded    = DW'(smooth_reg) + DW'(128);
    assign result     = rounded[DW-1:8];
    assign result_pol = cfg.invert_polarity ? -result : result;
    assign out_load   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next         = state_reg;
        in_ready           = 1'b0;
        win_ctl.wr_en      = 1'b0;
        win_ctl.sum_update = 1'b0;
        mac_req.en         = 1'b0;
        mac_req.a          = '0;
        mac_req.b          = '0;
        mac_req.c          = '0;
        unique case (state_reg)
            saf_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                win_ctl.wr_en = in_valid;
                if (in_valid)
                begin
                    state_next = saf_pkg::ST_SUM;
                end
            end
            saf_pkg::ST_SUM:
            begin
                win_ctl.sum_update = 1'b1;
                state_next         = saf_pkg::ST_AVG;
            end
            saf_pkg::ST_AVG:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MW'(sum);
                mac_req.b  = MW'(RECIP_D);
                state_next = saf_pkg::ST_MV_NUM;
            end
            saf_pkg::ST_MV_NUM:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MW'(sample);
                mac_req.b  = MW'(saf_pkg::MV_SCALE);
                mac_req.c  = CW'(saf_pkg::ROUND_2047);
                state_next = saf_pkg::ST_MV_DIV;
            end
            saf_pkg::ST_MV_DIV:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = prod[MW-1:0];
                mac_req.b  = MW'(saf_pkg::RECIP_2047);
                state_next = saf_pkg::ST_RAW_NUM;
            end
            saf_pkg::ST_RAW_NUM:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MW'(avg_clamped);
                mac_req.b  = MW'(cfg.angle_range);
                mac_req.c  = CW'(saf_pkg::ROUND_2047);
                state_next = saf_pkg::ST_RAW_DIV;
            end
            saf_pkg::ST_RAW_DIV:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = prod[MW-1:0];
                mac_req.b  = MW'(saf_pkg::RECIP_2047);
                state_next = saf_pkg::ST_WRAP;
            end
            saf_pkg::ST_WRAP:
            begin
                state_next = saf_pkg::ST_CLAMP;
            end
            saf_pkg::ST_CLAMP:
            begin
                state_next = saf_pkg::ST_DIFF;
            end
            saf_pkg::ST_DIFF:
            begin
                state_next = saf_pkg::ST_SMOOTH;
            end
            saf_pkg::ST_SMOOTH:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MW'(diff_reg);
                mac_req.b  = MW'(saf_pkg::ALPHA);
                mac_req.c  = CW'($signed({smooth_reg, 8'h80}));
                state_next = saf_pkg::ST_UPDATE;
            end
            saf_pkg::ST_UPDATE:
            begin
                state_next = saf_pkg::ST_OUT;
            end
            saf_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = saf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = saf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= saf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            saf_pkg::ST_MV_NUM:  avg_reg   <= prod[K_D +: saf_pkg::AVG_W];
            saf_pkg::ST_RAW_NUM: mv_reg    <= prod[RS +: saf_pkg::MV_W];
            saf_pkg::ST_WRAP:    rel_reg   <= rel_next;
            saf_pkg::ST_CLAMP:   angle_reg <= clamped[saf_pkg::ANGLE_W-1:0];
            saf_pkg::ST_DIFF:    diff_reg  <= diff_next;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == saf_pkg::ST_UPDATE)
            begin
                smooth_reg <= prod[8 +: STW];
            end
            if (state_reg == saf_pkg::ST_OUT && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == saf_pkg::ST_OUT && out_load)
        begin
            out_angle_reg <= result_pol[saf_pkg::ANGLE_W-1:0];
            out_avg_reg   <= avg_reg;
            out_mv_reg    <= mv_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign smoothed_angle    = out_angle_reg;
    assign averaged_adc      = out_avg_reg;
    assign sample_millivolts = out_mv_reg;

endmodule

// File: rtl/core/sensor_angle_filter_top.sv
// The sequencer accepts a new sample word only after the last one is through, stepping a single
// shared multiply-add unit through six operations; a full output register
// that is not taken holds the sequencer in its last step.
// Reset: the window reads 2048 in every entry, the smoothing state is zero,
// and the registers take their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
// sensor_angle_filter_top
// Angle sensor front end: moving average, angle scaling, exponential smoothing.
// ----------------------------------------------------------------------------
module sensor_angle_filter_top #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [14:0] smoothed_angle, [26:15] averaged_adc,
                                   // [39:27] sample_millivolts
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SUM_W = saf_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);

    saf_pkg::cfg_t       cfg_reg;
    saf_pkg::reg_index_t reg_index;
    saf_pkg::win_ctl_t   win_ctl;
    saf_pkg::mac_req_t   mac_req;
    logic                cfg_write;

    logic [saf_pkg::SAMPLE_W-1:0]        sample;
    logic [SUM_W-1:0]                    sum;
    logic signed [saf_pkg::MAC_P_W-1:0]  prod;
    logic [saf_pkg::ANGLE_W-1:0]         smoothed_angle;
    logic [saf_pkg::AVG_W-1:0]           averaged_adc;
    logic [saf_pkg::MV_W-1:0]            sample_millivolts;

    assign pready    = 1'b1;
    assign reg_index = saf_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_range     <= saf_pkg::RANGE_RESET;
            cfg_reg.angle_midpoint  <= '0;
            cfg_reg.angle_offset    <= '0;
            cfg_reg.invert_polarity <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                saf_pkg::REG_RANGE:    cfg_reg.angle_range     <= pwdata[14:0];
                saf_pkg::REG_MIDPOINT: cfg_reg.angle_midpoint  <= pwdata[14:0];
                saf_pkg::REG_OFFSET:   cfg_reg.angle_offset    <= pwdata[14:0];
                saf_pkg::REG_INVERT:   cfg_reg.invert_polarity <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            saf_pkg::REG_RANGE:    prdata = 32'(cfg_reg.angle_range);
            saf_pkg::REG_MIDPOINT: prdata = 32'(cfg_reg.angle_midpoint);
            saf_pkg::REG_OFFSET:   prdata = {17'd0, cfg_reg.angle_offset};
            saf_pkg::REG_INVERT:   prdata = 32'(cfg_reg.invert_polarity);
        endcase
    end

    saf_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (win_ctl),
        .sample_in (s_tdata[11:0]),
        .sample    (sample),
        .sum       (sum)
    );

    saf_mac u_mac (
        .clk  (clk),
        .req  (mac_req),
        .prod (prod)
    );

    saf_ctrl #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .win_ctl           (win_ctl),
        .sample            (sample),
        .sum               (sum),
        .mac_req           (mac_req),
        .prod              (prod),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .smoothed_angle    (smoothed_angle),
        .averaged_adc      (averaged_adc),
        .sample_millivolts (sample_millivolts)
    );

    assign m_tdata = {sample_millivolts, averaged_adc, smoothed_angle};

endmodule
